[rtl/core/pid_controller_modes_core_macros.svh]
// Assertion macros for the PID controller core
`ifndef PID_CONTROLLER_MODES_CORE_MACROS_SVH
`define PID_CONTROLLER_MODES_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PCM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/core/pcm_pkg.sv]
// Shared types and constants of the PID controller core
`timescale 1ns / 1ps
package pcm_pkg;

    localparam int SUM_W    = 48;
    localparam int MUL_W    = 30;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 64;
    localparam int GAIN_W   = 24;
    localparam int LIM_W    = 32;
    localparam int CFG_DW   = 32;
    localparam int CFG_AW   = 3;
    localparam int SPLIT    = 24;
    localparam int OPND_W   = 54;
    localparam int PROD_LOG = 60;
    localparam int OPND_LOG = 52;
    localparam int RECIP_SH = 30;
    // ceil(2^30 / 5)
    localparam logic [MUL_W-1:0] RECIP_5 = 30'd214748365;

    typedef enum logic [2:0] {
        MODE_POS,
        MODE_INC,
        MODE_SEP,
        MODE_AW,
        MODE_VAR,
        MODE_AWVAR
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        REG_MODE,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_UPPER,
        REG_LOWER,
        REG_SCALE
    } t_reg_idx;

    typedef enum logic [1:0] {
        W_ZERO,
        W_ONE,
        W_RAMP
    } t_wsel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_LAW,
        ST_DIV,
        ST_DIVW,
        ST_KI,
        ST_KIW,
        ST_LOAD,
        ST_HI,
        ST_LO,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIM_W-1:0]   upper;
        logic [LIM_W-1:0]   lower;
        logic [GAIN_W-1:0]  scale;
    } t_cfg;

    typedef struct packed {
        logic               acc;
        t_wsel              wsel;
        logic [MUL_W-1:0]   ramp_num;
    } t_law;

endpackage

[rtl/core/pcm_in_if.sv]
// Setpoint channel: valid, ready and one setpoint per item
`timescale 1ns / 1ps
interface pcm_in_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] setpoint;

    modport source (output valid, output setpoint, input ready);
    modport sink (input valid, input setpoint, output ready);
endinterface

[rtl/core/pcm_out_if.sv]
// Result channel: valid, ready and one output value per item
`timescale 1ns / 1ps
interface pcm_out_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] output_value;

    modport source (output valid, output output_value, input ready);
    modport sink (input valid, input output_value, output ready);
endinterface

[rtl/core/pcm_cfg.sv]
// Configuration register file of the PID controller core
`timescale 1ns / 1ps
module pcm_cfg #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pcm_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [pcm_pkg::CFG_DW-1:0]   i_cfg_data,
    output pcm_pkg::t_cfg                o_cfg
);
    import pcm_pkg::*;

    localparam logic [ACC_W-1:0] UPPER_FULL = 64'd400 << FRAC_BITS;
    localparam logic [ACC_W-1:0] LOWER_FULL = ~(64'd200 << FRAC_BITS) + 64'd1;
    localparam logic [ACC_W-1:0] SCALE_FULL = 64'd1 << FRAC_BITS;
    localparam logic [LIM_W-1:0]  UPPER_RST = UPPER_FULL[LIM_W-1:0];
    localparam logic [LIM_W-1:0]  LOWER_RST = LOWER_FULL[LIM_W-1:0];
    localparam logic [GAIN_W-1:0] SCALE_RST = SCALE_FULL[GAIN_W-1:0];

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] raw_mode;

    assign raw_mode = i_cfg_data[2:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE: begin
                    n_cfg.mode = (raw_mode > MODE_AWVAR) ? MODE_POS : t_mode'(raw_mode);
                end
                REG_GAIN_P: n_cfg.gain_p = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I: n_cfg.gain_i = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D: n_cfg.gain_d = i_cfg_data[GAIN_W-1:0];
                REG_UPPER:  n_cfg.upper  = i_cfg_data[LIM_W-1:0];
                REG_LOWER:  n_cfg.lower  = i_cfg_data[LIM_W-1:0];
                REG_SCALE:  n_cfg.scale  = i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_POS, gain_p: '0, gain_i: '0, gain_d: '0,
                       upper: UPPER_RST, lower: LOWER_RST, scale: SCALE_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pcm_mul.sv]
// Shared signed multiplier with registered product
`timescale 1ns / 1ps
module pcm_mul (
    input  logic                               i_clk,
    input  logic signed [pcm_pkg::MUL_W-1:0]   i_a,
    input  logic signed [pcm_pkg::MUL_W-1:0]   i_b,
    output logic signed [pcm_pkg::PROD_W-1:0]  o_p
);
    import pcm_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[rtl/core/pcm_law.sv]
// Integral weight and accumulate decision for the positional laws
`timescale 1ns / 1ps
module pcm_law #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  pcm_pkg::t_cfg                  i_cfg,
    input  logic signed [VALUE_WIDTH-1:0]  i_err,
    input  logic signed [VALUE_WIDTH-1:0]  i_last,
    output pcm_pkg::t_law                  o_law
);
    import pcm_pkg::*;

    localparam int CW = ((VALUE_WIDTH > FRAC_BITS + 9) ? VALUE_WIDTH : FRAC_BITS + 9) + 1;
    localparam logic [CW-1:0] SEP_LIM  = CW'(200) << FRAC_BITS;
    localparam logic [CW-1:0] RAMP_LIM = CW'(180) << FRAC_BITS;

    logic [VALUE_WIDTH-1:0]   abs_err;
    logic [CW-1:0]            abs_cw;
    logic [CW-1:0]            ramp_diff;
    logic signed [ACC_W-1:0]  last_x;
    logic signed [ACC_W-1:0]  up_x;
    logic signed [ACC_W-1:0]  lo_x;
    logic                     sep_on;
    logic                     var_on;
    logic                     aw_on;
    logic                     err_neg;
    logic                     err_pos;

    assign abs_err   = i_err[VALUE_WIDTH-1] ? (~i_err + 1'b1) : i_err;
    assign abs_cw    = CW'(abs_err);
    assign ramp_diff = (SEP_LIM - abs_cw) >> 2;
    assign last_x    = ACC_W'(i_last);
    assign up_x      = ACC_W'($signed(i_cfg.upper));
    assign lo_x      = ACC_W'($signed(i_cfg.lower));
    assign sep_on    = (i_cfg.mode == MODE_SEP) || (i_cfg.mode == MODE_AW) ||
                       (i_cfg.mode == MODE_VAR) || (i_cfg.mode == MODE_AWVAR);
    assign var_on    = (i_cfg.mode == MODE_VAR) || (i_cfg.mode == MODE_AWVAR);
    assign aw_on     = (i_cfg.mode == MODE_AW) || (i_cfg.mode == MODE_AWVAR);
    assign err_neg   = i_err[VALUE_WIDTH-1];
    assign err_pos   = !i_err[VALUE_WIDTH-1] && (i_err != '0);

    always_comb begin
        o_law.acc      = 1'b1;
        o_law.wsel     = W_ONE;
        o_law.ramp_num = MUL_W'(ramp_diff);
        if (sep_on && (abs_cw > SEP_LIM)) begin
            o_law.wsel = W_ZERO;
            o_law.acc  = 1'b0;
        end else if (var_on && (abs_cw >= RAMP_LIM)) begin
            o_law.wsel = W_RAMP;
        end
        if (o_law.acc && aw_on) begin
            if (last_x > up_x) begin
                o_law.acc = err_neg;
            end else if (last_x < lo_x) begin
                o_law.acc = err_pos;
            end
        end
    end

endmodule

[rtl/core/pid_controller_modes_core.sv]
// PID controller with six control laws, sequenced around one shared multiplier
//
//   channel     dir  handshake          payload
//   i_sp_chan   in   valid / ready      setpoint      (VALUE_WIDTH, signed)
//   o_res_chan  out  valid / ready      output_value  (VALUE_WIDTH, signed)
//   cfg port    in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// One setpoint is taken at a time; ready is high only while idle. The
// positional laws weight the integral gain first, with a divide step on the
// ramp. Each product term takes two passes through the single 30x30 multiplier.
// Synchronous active-low reset clears the sequencer, the output valid flag and
// the controller state; config takes its documented defaults.
// A stalled result waits in the output register while the next item runs.
`timescale 1ns / 1ps
`include "pid_controller_modes_core_macros.svh"
module pid_controller_modes_core #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pcm_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [pcm_pkg::CFG_DW-1:0]  i_cfg_data,
    pcm_in_if.sink                      i_sp_chan,
    pcm_out_if.source                   o_res_chan
);
    import pcm_pkg::*;

    localparam int SHIFT_S = SPLIT - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] VMAX = ACC_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;
    localparam logic signed [ACC_W-1:0] P_LIM = ACC_W'(64'd1 << PROD_LOG);
    localparam logic signed [ACC_W-1:0] P_NEG = ~P_LIM + ACC_W'(1);
    localparam logic signed [ACC_W-1:0] PH_LIM = ACC_W'(64'd1 << (PROD_LOG - SHIFT_S));
    localparam logic signed [ACC_W-1:0] PH_NEG = ~PH_LIM + ACC_W'(1);
    localparam logic signed [ACC_W-1:0] O_LIM = ACC_W'(64'd1 << OPND_LOG);
    localparam logic signed [ACC_W-1:0] O_NEG = ~O_LIM + ACC_W'(1);
    localparam logic signed [SUM_W:0] SMAX = {2'b00, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W:0] SMIN = {2'b11, {(SUM_W - 1){1'b0}}};
    localparam logic [MUL_W-1:0] WEIGHT_ONE = MUL_W'(64'd1 << FRAC_BITS);

    function automatic logic signed [VALUE_WIDTH-1:0] sat_v(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > VMAX) begin
            c = VMAX;
        end else if (v < VMIN) begin
            c = VMIN;
        end
        return VALUE_WIDTH'(c);
    endfunction

    t_cfg   cfg;
    t_law   law;
    t_state r_state, n_state;

    logic signed [VALUE_WIDTH-1:0] r_sp, n_sp;
    logic signed [VALUE_WIDTH-1:0] r_err, n_err;
    logic signed [VALUE_WIDTH-1:0] r_last, n_last;
    logic signed [VALUE_WIDTH-1:0] r_prev, n_prev;
    logic signed [VALUE_WIDTH-1:0] r_older, n_older;
    logic signed [VALUE_WIDTH-1:0] r_odata, n_odata;
    logic signed [SUM_W-1:0]       r_esum, n_esum;
    logic [MUL_W-1:0]              r_x, n_x;
    logic [MUL_W-1:0]              r_w, n_w;
    logic signed [GAIN_W-1:0]      r_ki, n_ki;
    logic [1:0]                    r_term, n_term;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic signed [MUL_W-1:0]       r_opa, n_opa;
    logic signed [OPND_W-1:0]      r_opb, n_opb;
    logic signed [PROD_W-1:0]      r_ph, n_ph;
    logic                          r_ovalid, n_ovalid;

    logic signed [ACC_W-1:0]  err_raw;
    logic signed [ACC_W-1:0]  e_x;
    logic signed [ACC_W-1:0]  prev_x;
    logic signed [ACC_W-1:0]  older_x;
    logic signed [ACC_W-1:0]  last_x;
    logic signed [ACC_W-1:0]  b_sel;
    logic signed [ACC_W-1:0]  ph_x;
    logic signed [ACC_W-1:0]  pl_x;
    logic signed [ACC_W-1:0]  lin_r;
    logic signed [ACC_W-1:0]  term_r;
    logic signed [ACC_W-1:0]  fin_inc;
    logic signed [MUL_W-1:0]  a_sel;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [OPND_W-1:0] b_clamp;
    logic signed [SUM_W:0]    esum_raw;
    logic signed [SUM_W-1:0]  esum_sat;
    logic [1:0]               last_term;
    logic                     sp_acc;

    pcm_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pcm_law #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_law (
        .i_cfg  (cfg),
        .i_err  (r_err),
        .i_last (r_last),
        .o_law  (law)
    );

    pcm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign i_sp_chan.ready         = (r_state == ST_IDLE);
    assign sp_acc                  = i_sp_chan.valid && i_sp_chan.ready;
    assign o_res_chan.valid        = r_ovalid;
    assign o_res_chan.output_value = r_odata;

    assign e_x      = ACC_W'(r_err);
    assign prev_x   = ACC_W'(r_prev);
    assign older_x  = ACC_W'(r_older);
    assign last_x   = ACC_W'(r_last);
    assign err_raw  = ACC_W'(r_sp) - last_x;
    assign esum_raw = (SUM_W + 1)'(r_esum) + (SUM_W + 1)'(r_err);
    assign esum_sat = (esum_raw > SMAX) ? SUM_W'(SMAX) :
                      (esum_raw < SMIN) ? SUM_W'(SMIN) : SUM_W'(esum_raw);
    assign last_term = (cfg.mode == MODE_INC) ? 2'd2 : 2'd3;

    // operands of the current product term
    always_comb begin
        a_sel = '0;
        b_sel = '0;
        if (cfg.mode == MODE_INC) begin
            case (r_term)
                2'd0: begin
                    a_sel = MUL_W'($signed(cfg.gain_p));
                    b_sel = e_x - older_x;
                end
                2'd1: begin
                    a_sel = MUL_W'($signed(cfg.gain_i));
                    b_sel = e_x;
                end
                default: begin
                    a_sel = MUL_W'($signed(cfg.gain_d));
                    b_sel = e_x - (older_x <<< 1) + prev_x;
                end
            endcase
        end else begin
            case (r_term)
                2'd0: begin
                    a_sel = MUL_W'($signed(cfg.gain_p));
                    b_sel = e_x;
                end
                2'd1: begin
                    a_sel = MUL_W'(r_ki);
                    b_sel = ACC_W'(r_esum);
                end
                2'd2: begin
                    a_sel = MUL_W'($signed(cfg.gain_d));
                    b_sel = e_x - prev_x;
                end
                default: begin
                    a_sel = MUL_W'($signed({1'b0, cfg.scale}));
                    b_sel = r_acc;
                end
            endcase
        end
        if (b_sel > O_LIM) begin
            b_clamp = OPND_W'(O_LIM);
        end else if (b_sel < O_NEG) begin
            b_clamp = OPND_W'(O_NEG);
        end else begin
            b_clamp = OPND_W'(b_sel);
        end
    end

    // recombine the high and low partial products
    always_comb begin
        ph_x  = ACC_W'(r_ph);
        pl_x  = ACC_W'(mul_p) >>> FRAC_BITS;
        lin_r = (ph_x <<< SHIFT_S) + pl_x;
        if (ph_x > PH_LIM) begin
            term_r = P_LIM;
        end else if (ph_x < PH_NEG) begin
            term_r = P_NEG;
        end else if (lin_r > P_LIM) begin
            term_r = P_LIM;
        end else if (lin_r < P_NEG) begin
            term_r = P_NEG;
        end else begin
            term_r = lin_r;
        end
    end

    assign fin_inc = last_x + r_acc + term_r;

    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_err    = r_err;
        n_last   = r_last;
        n_prev   = r_prev;
        n_older  = r_older;
        n_odata  = r_odata;
        n_esum   = r_esum;
        n_x      = r_x;
        n_w      = r_w;
        n_ki     = r_ki;
        n_term   = r_term;
        n_acc    = r_acc;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_ph     = r_ph;
        n_ovalid = r_ovalid;
        mul_a    = '0;
        mul_b    = '0;
        if (r_ovalid && o_res_chan.ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (sp_acc) begin
                    n_sp    = i_sp_chan.setpoint;
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                n_err   = sat_v(err_raw);
                n_state = ST_LAW;
            end
            ST_LAW: begin
                n_term = 2'd0;
                n_acc  = '0;
                if (cfg.mode == MODE_INC) begin
                    n_state = ST_LOAD;
                end else begin
                    if (law.acc) begin
                        n_esum = esum_sat;
                    end
                    n_state = ST_KI;
                    case (law.wsel)
                        W_ZERO: n_w = '0;
                        W_RAMP: begin
                            n_x     = law.ramp_num;
                            n_state = ST_DIV;
                        end
                        default: n_w = WEIGHT_ONE;
                    endcase
                end
            end
            ST_DIV: begin
                mul_a   = r_x;
                mul_b   = RECIP_5;
                n_state = ST_DIVW;
            end
            ST_DIVW: begin
                n_w     = MUL_W'(mul_p >>> RECIP_SH);
                n_state = ST_KI;
            end
            ST_KI: begin
                mul_a   = MUL_W'($signed(cfg.gain_i));
                mul_b   = r_w;
                n_state = ST_KIW;
            end
            ST_KIW: begin
                n_ki    = GAIN_W'(mul_p >>> FRAC_BITS);
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_opa   = a_sel;
                n_opb   = b_clamp;
                n_state = ST_HI;
            end
            ST_HI: begin
                mul_a   = r_opa;
                mul_b   = r_opb[OPND_W-1:SPLIT];
                n_state = ST_LO;
            end
            ST_LO: begin
                mul_a   = r_opa;
                mul_b   = MUL_W'({1'b0, r_opb[SPLIT-1:0]});
                n_ph    = mul_p;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_term == last_term) begin
                    if (cfg.mode == MODE_INC) begin
                        n_last  = sat_v(fin_inc);
                        n_prev  = r_older;
                        n_older = r_err;
                    end else begin
                        n_last = sat_v(term_r);
                        n_prev = r_err;
                    end
                    n_state = ST_DONE;
                end else begin
                    n_acc   = r_acc + term_r;
                    n_term  = r_term + 2'd1;
                    n_state = ST_LOAD;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_res_chan.ready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_last;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_last   <= '0;
            r_prev   <= '0;
            r_older  <= '0;
            r_esum   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_last   <= n_last;
            r_prev   <= n_prev;
            r_older  <= n_older;
            r_esum   <= n_esum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp    <= n_sp;
        r_err   <= n_err;
        r_odata <= n_odata;
        r_x     <= n_x;
        r_w     <= n_w;
        r_ki    <= n_ki;
        r_term  <= n_term;
        r_acc   <= n_acc;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_ph    <= n_ph;
    end

    `PCM_ASSERT(a_busy_after_take, i_clk, i_rst_n, sp_acc |=> !i_sp_chan.ready, "ready right after an item was taken")
    `PCM_ASSERT(a_result_from_done, i_clk, i_rst_n, $rose(r_ovalid) |-> $past(r_state == ST_DONE), "result raised outside the done step")
    `PCM_ASSERT(a_inc_keeps_sum, i_clk, i_rst_n, (r_state == ST_LAW) && (cfg.mode == MODE_INC) |=> $stable(r_esum), "error sum moved in incremental law")
    `PCM_ASSERT(a_sum_after_low, i_clk, i_rst_n, (r_state == ST_SUM) |-> $past(r_state == ST_LO), "partial products combined out of order")
    `PCM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE) && !r_ovalid, "sequencer not idle after reset")

endmodule

[sim/testbench.sv]
// Self-checking testbench of the PID controller core across all six control laws
`timescale 1ns / 1ps
import pcm_pkg::*;

class pid_scoreboard;
    localparam longint PROD_CAP = 64'sd1152921504606846976;
    localparam longint OPND_CAP = 64'sd4503599627370496;
    localparam longint SUM_MAX  = 64'sd140737488355327;
    localparam longint VAL_MAX  = 64'sd2147483647;
    localparam longint FX_ONE   = 64'sd65536;

    logic [2:0] mode;
    longint gain_p, gain_i, gain_d, upper, lower, scale;
    longint last_out, err_sum, prev_err, older_err;
    logic signed [31:0] expected_outputs[$];
    int fails;

    function new();
        fails = 0;
        mode = MODE_POS;
        gain_p = 0;
        gain_i = 0;
        gain_d = 0;
        upper = 400 * FX_ONE;
        lower = -200 * FX_ONE;
        scale = FX_ONE;
        last_out = 0;
        err_sum = 0;
        prev_err = 0;
        older_err = 0;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function void set_reg(t_reg_idx idx, logic [31:0] data);
        case (idx)
            REG_MODE:   mode = data[2:0];
            REG_GAIN_P: gain_p = longint'($signed(data[23:0]));
            REG_GAIN_I: gain_i = longint'($signed(data[23:0]));
            REG_GAIN_D: gain_d = longint'($signed(data[23:0]));
            REG_UPPER:  upper = longint'($signed(data));
            REG_LOWER:  lower = longint'($signed(data));
            REG_SCALE:  scale = {40'd0, data[23:0]};
            default: ;
        endcase
    endfunction

    // floor(a * b / 2^16) with the operand and product caps of the datapath
    function longint mul_frac(longint a, longint b);
        longint lo, hi, ph, r;
        b = clamp(b, -OPND_CAP, OPND_CAP);
        lo = b & 64'sd16777215;
        hi = b >>> 24;
        ph = a * hi;
        if (ph > (PROD_CAP >>> 8))
            return PROD_CAP;
        if (ph < -(PROD_CAP >>> 8))
            return -PROD_CAP;
        r = ph * 256 + ((a * lo) >>> 16);
        return clamp(r, -PROD_CAP, PROD_CAP);
    endfunction

    function void next_output(logic signed [31:0] sp);
        longint e, mag, w, ki, t, drive, res;
        bit acc;
        logic [2:0] m;
        e = clamp(longint'(sp) - last_out, -VAL_MAX - 1, VAL_MAX);
        mag = e < 0 ? -e : e;
        w = FX_ONE;
        acc = 1'b1;
        m = (mode > MODE_AWVAR) ? MODE_POS : mode;
        if (m == MODE_INC) begin
            t = mul_frac(gain_p, e - older_err) + mul_frac(gain_i, e)
              + mul_frac(gain_d, e - 2 * older_err + prev_err);
            res = clamp(last_out + t, -VAL_MAX - 1, VAL_MAX);
            prev_err = older_err;
            older_err = e;
        end else begin
            if (m >= MODE_SEP) begin
                if (mag > 200 * FX_ONE) begin
                    w = 0;
                    acc = 1'b0;
                end else if (m >= MODE_VAR && mag >= 180 * FX_ONE) begin
                    w = (200 * FX_ONE - mag) / 20;
                end
            end
            if (acc && (m == MODE_AW || m == MODE_AWVAR)) begin
                if (last_out > upper)
                    acc = (e < 0);
                else if (last_out < lower)
                    acc = (e > 0);
            end
            if (acc)
                err_sum = clamp(err_sum + e, -SUM_MAX - 1, SUM_MAX);
            ki = (gain_i * w) >>> 16;
            drive = mul_frac(gain_p, e) + mul_frac(ki, err_sum) + mul_frac(gain_d, e - prev_err);
            res = clamp(mul_frac(scale, drive), -VAL_MAX - 1, VAL_MAX);
            prev_err = e;
        end
        last_out = res;
        expected_outputs.push_back(32'(res));
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        fails++;
    endtask

    task check_output(logic signed [31:0] got);
        logic signed [31:0] want;
        if (expected_outputs.size() == 0) begin
            report($sformatf("output %0d arrived with nothing expected", got));
            return;
        end
        want = expected_outputs.pop_front();
        if (got !== want)
            report($sformatf("output_value got %0d, expected %0d", got, want));
    endtask

    function int pending();
        return expected_outputs.size();
    endfunction
endclass

module testbench;
    localparam int          VW             = 32;
    localparam int unsigned CYCLE_LIMIT    = 500000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          LONG_HOLD      = 300;
    localparam int          NUM_PHASES     = 12;
    localparam int          PHASE_ITEMS    = 90;
    localparam longint      FX             = 65536;
    localparam longint      VMAX           = 64'sd2147483647;
    localparam longint      VMIN           = -64'sd2147483648;
    localparam longint      GAIN_MAX       = 8388607;
    localparam longint      GAIN_MIN       = -8388608;
    localparam longint      SCALE_MAX      = 16777215;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_idx;
    logic [CFG_DW-1:0]   i_cfg_data;
    bit                  stall_on;
    bit                  long_hold;
    int unsigned         cycle_count = 0;
    pid_scoreboard       sb;

    pcm_in_if  #(.VALUE_WIDTH(VW)) sp_ch ();
    pcm_out_if #(.VALUE_WIDTH(VW)) res_ch ();

    pid_controller_modes_core #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS  (16)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_sp_chan (sp_ch),
        .o_res_chan(res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL pid_controller_modes_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_output(res_ch.output_value);
    end

    initial begin
        int hold_count;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                hold_count = 0;
                while (hold_count < LONG_HOLD) begin
                    @(posedge i_clk);
                    hold_count++;
                end
                long_hold = 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_setpoint(logic signed [31:0] sp);
        sp_ch.valid <= 1'b1;
        sp_ch.setpoint <= sp;
        @(posedge i_clk);
        while (!sp_ch.ready) @(posedge i_clk);
        sb.next_output(sp);
    endtask

    task automatic sender_gap();
        if (stall_on && $urandom_range(0, 3) == 0) begin
            sp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        sp_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, longint value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 32'(value);
        sb.set_reg(idx, 32'(value));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(t_mode md, longint gp, longint gi, longint gd,
                             longint up, longint lo, longint sc);
        write_reg(REG_MODE, md);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_UPPER, up);
        write_reg(REG_LOWER, lo);
        write_reg(REG_SCALE, sc);
    endtask

    function automatic logic signed [31:0] near_last(longint d);
        return 32'(sb.clamp(sb.last_out + d, VMIN, VMAX));
    endfunction

    function automatic longint pick_gain();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: return GAIN_MIN;
            1: return GAIN_MAX;
            2: return longint'($signed(raw[23:0]));
            default: return longint'($urandom_range(0, 80000)) - 40000;
        endcase
    endfunction

    function automatic longint pick_limit();
        case ($urandom_range(0, 7))
            0: return VMIN;
            1: return VMAX;
            default: return longint'($urandom_range(0, 1000 * 65536)) - 500 * FX;
        endcase
    endfunction

    function automatic longint pick_scale();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return SCALE_MAX;
            2: return longint'($urandom_range(0, SCALE_MAX));
            default: return longint'($urandom_range(32768, 98304));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_setpoint();
        longint d;
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            2, 3, 4: begin
                d = longint'($urandom_range(170 * 65536, 210 * 65536));
                return near_last($urandom_range(0, 1) ? -d : d);
            end
            default: return near_last(longint'($urandom_range(0, 500 * 65536)) - 250 * FX);
        endcase
    endfunction

    initial begin
        t_mode md;
        sb = new();
        stall_on = 1'b1;
        long_hold = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_MODE;
        i_cfg_data <= '0;
        sp_ch.valid <= 1'b0;
        sp_ch.setpoint <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // boundaries of the weight ramp, separation, anti-windup and the value extremes
        configure(MODE_POS, 32768, 4096, 8192, 50 * FX, -50 * FX, FX);
        for (int m = MODE_POS; m <= MODE_AWVAR; m++) begin
            if (m != MODE_POS) begin
                drain();
                write_reg(REG_MODE, m);
            end
            send_setpoint(near_last(190 * FX));
            send_setpoint(near_last(-205 * FX));
            send_setpoint((m % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
            send_setpoint(near_last(m < MODE_AW ? 200 * FX : -180 * FX));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            md = t_mode'(p % (MODE_AWVAR + 1));
            if (p == 6)
                configure(md, GAIN_MAX, GAIN_MAX, GAIN_MAX, VMAX, VMIN, SCALE_MAX);
            else if (p == 10)
                configure(md, GAIN_MIN, GAIN_MIN, GAIN_MIN, VMIN, VMAX, 0);
            else
                configure(md, pick_gain(), pick_gain(), pick_gain(),
                          pick_limit(), pick_limit(), pick_scale());
            stall_on = (p != 3 && p != NUM_PHASES - 1);
            if (p == 2)
                long_hold = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                sender_gap();
                send_setpoint(pick_setpoint());
                if (p == 4 && i == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        if (sb.fails == 0 && sb.pending() == 0)
            $display("PASS pid_controller_modes_core");
        else
            $display("FAIL pid_controller_modes_core");
        $finish;
    end
endmodule
